// ----- hdl/grma_pkg.sv -----
// Package for the glitch-rejecting moving average.
// Holds field widths, reset values, register indexes, the controller state type
// and the command and status structs shared by the controller and the datapath.
package grma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int WLEN_W         = 6;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int WINDOW_MAX_DEF = 32;

  localparam logic [WLEN_W-1:0]   WINDOW_LEN_RST = 6'd8;
  localparam logic [SAMPLE_W-1:0] MAX_STEP_RST   = 16'd100;

  // Recovery needs four good samples; the counter wraps after its last value.
  localparam logic [1:0] RECOVER_LAST = 2'd3;
  localparam logic [3:0] FAIL_LIMIT   = 4'd10;
  localparam logic [3:0] REJECT_MAX   = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_FILL,
    S_SHIFT,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic fill;
    logic shift;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic primed;
    logic ok;
    logic in_error;
    logic fill_last;
    logic div_last;
  } status_t;

endpackage

// ----- hdl/grma_ctrl.sv -----
// Controller for the glitch-rejecting moving average.
// Sequences decision, window refill, shift, serial division and output loading.
// Depends on grma_pkg for the state type and the command and status structs.
module grma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  output logic               result_valid,
  input  logic               result_stall,
  input  grma_pkg::status_t  status,
  output grma_pkg::cmd_t     cmd
);
  import grma_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.primed) begin
          state_next = S_FILL;
        end else if (status.ok && !status.in_error) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // The output register is free, or its request is taken in this cycle.
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // No request is taken while reset is held.
  assign sample_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || !result_stall))
    else $error("output register overwritten while its request is stalled");

  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (state == S_DECIDE))
    else $error("accepted sample not followed by a decision");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result request dropped");
`endif

endmodule

// ----- hdl/grma_datapath.sv -----
// Datapath for the glitch-rejecting moving average.
// Holds configuration, the sample window memory, the window sum, the error state,
// the bit-serial divider and the output register. Depends on grma_pkg.
module grma_datapath #(
  parameter int WINDOW_MAX = grma_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [grma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grma_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [grma_pkg::SAMPLE_W-1:0]      sample,
  input  grma_pkg::cmd_t                     cmd,
  output grma_pkg::status_t                  status,
  output logic [grma_pkg::SAMPLE_W-1:0]      filtered,
  output logic                               rejected,
  output logic                               sensor_fail
);
  import grma_pkg::*;

  localparam int LW    = $clog2(WINDOW_MAX + 1);
  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CMPW  = (LW > WLEN_W) ? LW : WLEN_W;
  localparam int SUM_W = SAMPLE_W + LW;
  localparam int DCW   = $clog2(SUM_W + 1);
  localparam int CW    = SAMPLE_W + 2;

  logic [WLEN_W-1:0]   window_len;
  logic [SAMPLE_W-1:0] max_step;

  logic [SAMPLE_W-1:0] window_mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rd_data;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;

  logic [SAMPLE_W-1:0] s_reg;
  logic [SAMPLE_W-1:0] newest;
  logic [AW-1:0]       base;
  logic [SUM_W-1:0]    sum;
  logic                primed;
  logic                in_error;
  logic [1:0]          recover_count;
  logic [3:0]          reject_count;
  logic [SAMPLE_W-1:0] held_output;
  logic                rej_flag;

  logic [SUM_W-1:0]    quo;
  logic [LW-1:0]       rem;
  logic [DCW-1:0]      div_cnt;

  logic [CMPW-1:0]     wl_ext;
  logic [LW-1:0]       len;
  logic [LW-1:0]       len_m1;
  logic [AW-1:0]       base_next;
  logic [AW-1:0]       newest_addr;
  logic                ok;
  logic signed [CW-1:0] v_s;
  logic signed [CW-1:0] n_s;
  logic signed [CW-1:0] st_s;
  logic [SUM_W-1:0]    sum_shift;
  logic [SUM_W-1:0]    sum_reject;
  logic [LW:0]         rem_sh;
  logic [LW:0]         rem_sub;
  logic                ge;
  logic [LW-1:0]       rem_next;
  logic [SUM_W-1:0]    quo_next;

  // Effective window length: zero acts as one, anything beyond the store is clipped.
  always_comb begin
    wl_ext = CMPW'(window_len);
    if (wl_ext == '0) begin
      len = LW'(1);
    end else if (wl_ext > CMPW'(WINDOW_MAX)) begin
      len = LW'(WINDOW_MAX);
    end else begin
      len = wl_ext[LW-1:0];
    end
  end

  assign len_m1      = len - LW'(1);
  assign base_next   = (LW'(base) == len_m1) ? '0 : base + AW'(1);
  assign newest_addr = (base == '0) ? AW'(len_m1) : base - AW'(1);

  // Jump check, signed at a width where the differences cannot wrap.
  assign v_s  = signed'(CW'(s_reg));
  assign n_s  = signed'(CW'(newest));
  assign st_s = signed'(CW'(max_step));
  assign ok   = (s_reg != '0) && (v_s < n_s + st_s) &&
                ((v_s <= st_s) || (v_s > n_s - st_s));

  // The sum always covers the stored window, including overwrites on rejection.
  assign sum_shift  = sum + SUM_W'(s_reg) - SUM_W'(rd_data);
  assign sum_reject = sum + SUM_W'(s_reg) - SUM_W'(newest);

  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, len};
  assign ge       = (rem_sh >= {1'b0, len});
  assign rem_next = ge ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
  assign quo_next = {quo[SUM_W-2:0], ge};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base;
    if (cmd.fill || cmd.shift) begin
      mem_we = 1'b1;
    end else if (cmd.decide && primed && !ok) begin
      mem_we    = 1'b1;
      mem_waddr = newest_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[mem_waddr] <= s_reg;
    end
    rd_data <= window_mem[base];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len    <= WINDOW_LEN_RST;
      max_step      <= MAX_STEP_RST;
      primed        <= 1'b0;
      in_error      <= 1'b0;
      recover_count <= '0;
      reject_count  <= '0;
      held_output   <= '0;
      sum           <= '0;
      base          <= '0;
      div_cnt       <= '0;
      rej_flag      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len <= cfg_data[WLEN_W-1:0];
            primed     <= 1'b0;
          end
          REG_MAX_STEP: begin
            max_step <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (cmd.decide) begin
        if (!primed) begin
          base         <= '0;
          sum          <= '0;
          held_output  <= s_reg;
          in_error     <= 1'b0;
          reject_count <= '0;
          primed       <= (len > LW'(1));
          rej_flag     <= 1'b0;
        end else if (ok) begin
          rej_flag <= 1'b0;
          if (in_error) begin
            if (recover_count != RECOVER_LAST) begin
              recover_count <= recover_count + 2'd1;
            end else begin
              recover_count <= '0;
              reject_count  <= '0;
              primed        <= 1'b0;
            end
          end
        end else begin
          sum           <= sum_reject;
          in_error      <= 1'b1;
          recover_count <= '0;
          rej_flag      <= 1'b1;
          if (reject_count != REJECT_MAX) begin
            reject_count <= reject_count + 4'd1;
          end
        end
      end

      if (cmd.fill) begin
        sum  <= sum + SUM_W'(s_reg);
        base <= base_next;
      end

      if (cmd.shift) begin
        sum     <= sum_shift;
        base    <= base_next;
        div_cnt <= DCW'(SUM_W);
      end

      if (cmd.div_step) begin
        div_cnt <= div_cnt - DCW'(1);
        if (div_cnt == DCW'(1)) begin
          held_output <= quo_next[SAMPLE_W-1:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_reg <= sample;
    end
    if ((cmd.decide && (!primed || !ok)) || cmd.shift) begin
      newest <= s_reg;
    end
    if (cmd.shift) begin
      quo <= sum_shift;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (cmd.load_out) begin
      filtered    <= held_output;
      rejected    <= rej_flag;
      sensor_fail <= (reject_count > FAIL_LIMIT);
    end
  end

  always_comb begin
    status.primed    = primed;
    status.ok        = ok;
    status.in_error  = in_error;
    status.fill_last = (LW'(base) == len_m1);
    status.div_last  = (div_cnt == DCW'(1));
  end

`ifndef ASSERT_OFF
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    primed |-> (LW'(base) <= len_m1))
    else $error("window pointer beyond the effective length");

  a_reject_error: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && primed && !ok) |=> (in_error && rej_flag))
    else $error("rejected sample did not raise the error state");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (rem < len))
    else $error("divider remainder not below the window length");
`endif

endmodule

// ----- hdl/glitch_rejecting_moving_average.sv -----
// Glitch-rejecting moving average for load-cell samples. One sample is taken at
// a time and each gives exactly one result; the next sample is taken while the
// previous result still waits in the output register. A refill (first sample,
// after re-arming, or after a window_len write) writes every entry of the effective
// window length. A rejected sample, or a good one during recovery, skips the refill
// and the divider. An accepted sample outside the error state goes through the
// restoring divider, which produces one quotient bit a cycle.
// Depends on grma_pkg, grma_ctrl and grma_datapath.
module glitch_rejecting_moving_average #(
  parameter int WINDOW_MAX = grma_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [grma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grma_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [grma_pkg::SAMPLE_W-1:0]      sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [grma_pkg::SAMPLE_W-1:0]      filtered,
  output logic                               rejected,
  output logic                               sensor_fail
);
  import grma_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg_ready = !rst;
  assign cfg_we    = cfg_valid && cfg_ready;

  grma_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  grma_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .cmd         (cmd),
    .status      (status),
    .filtered    (filtered),
    .rejected    (rejected),
    .sensor_fail (sensor_fail)
  );

endmodule

// ----- tb/sv/glitch_rejecting_moving_average_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the glitch-rejecting moving average: a directed table of requests,
// then phases of drifting random load-cell readings with glitches, checked against a local model.
// Depends on grma_pkg and glitch_rejecting_moving_average.
module glitch_rejecting_moving_average_test;
  import grma_pkg::*;

  localparam int WIN_MAX      = WINDOW_MAX_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_ITEMS  = 120;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_CAP    = 200;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                rejected;
    logic                sensor_fail;
  } reading_t;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
    logic                  pinned;
    reading_t              reading;
  } row_t;

  localparam int PLAN_ROWS = 33;
  localparam row_t PLAN [PLAN_ROWS] = '{
    '{ROW_SAMPLE, '0, 16'd1000, 1'b1, '{16'd1000, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd50, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd60, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd70, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd80, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd500, 1'b1, '{16'd500, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{16'd500, 1'b1, 1'b1}},
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'd1, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd0, 1'b1, '{16'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'd32, 1'b0, '0},
    '{ROW_CONFIG, REG_MAX_STEP, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'd1, 1'b0, '0},
    '{ROW_CONFIG, REG_MAX_STEP, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd5, 1'b0, '0},
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'd0, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'd7, 1'b1, '{16'd7, 1'b0, 1'b0}},
    '{ROW_CONFIG, REG_MAX_STEP, 16'd200, 1'b0, '0},
    '{ROW_CONFIG, REG_WINDOW_LEN, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b0}},
    '{ROW_SAMPLE, '0, 16'd65500, 1'b0, '0}
  };

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [SAMPLE_W-1:0]   sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [SAMPLE_W-1:0]   filtered;
  logic                  rejected;
  logic                  sensor_fail;

  glitch_rejecting_moving_average i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered     (filtered),
    .rejected     (rejected),
    .sensor_fail  (sensor_fail)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the filter state and its two registers.
  logic [SAMPLE_W-1:0] win_m [WIN_MAX];
  logic [WLEN_W-1:0]   wlen_m    = WINDOW_LEN_RST;
  logic [SAMPLE_W-1:0] step_m    = MAX_STEP_RST;
  bit                  primed_m  = 1'b0;
  bit                  error_m   = 1'b0;
  logic [1:0]          recover_m = '0;
  logic [3:0]          rejects_m = '0;
  logic [SAMPLE_W-1:0] held_m    = '0;

  reading_t pending_readings [$];
  row_t     pinned_readings [$];

  bit quiet        = 1'b0;
  bit hold_request = 1'b0;
  int failures     = 0;
  int samples_taken, results_checked, rejections_seen, alarms_seen, config_writes;
  int cycles       = 0;

  function automatic reading_t filter_sample(input logic [SAMPLE_W-1:0] s);
    int          len, newest, step, v, i;
    int unsigned acc;
    bit          ok;
    reading_t    r;
    len = (wlen_m == 0) ? 1 : ((wlen_m > WIN_MAX) ? WIN_MAX : int'(wlen_m));
    r.rejected = 1'b0;
    if (!primed_m) begin
      for (i = 0; i < len; i++) win_m[i] = s;
      held_m    = s;
      error_m   = 1'b0;
      rejects_m = '0;
      primed_m  = (len > 1);
    end else begin
      newest = int'(win_m[len-1]);
      step   = int'(step_m);
      v      = int'(s);
      ok = (v > 0) && (v < newest + step) && ((v <= step) || (v > newest - step));
      if (ok && error_m) begin
        // Four good samples in a row re-arm the filter; the window is untouched meanwhile.
        if (recover_m < RECOVER_LAST) begin
          recover_m++;
        end else begin
          recover_m = '0;
          rejects_m = '0;
          primed_m  = 1'b0;
        end
      end else if (ok) begin
        for (i = 0; i < len - 1; i++) win_m[i] = win_m[i+1];
        win_m[len-1] = s;
        acc = 0;
        for (i = 0; i < len; i++) acc += win_m[i];
        held_m = SAMPLE_W'(acc / len);
      end else begin
        win_m[len-1] = s;
        error_m      = 1'b1;
        recover_m    = '0;
        if (rejects_m < REJECT_MAX) rejects_m++;
        r.rejected = 1'b1;
      end
    end
    r.filtered    = held_m;
    r.sensor_fail = (rejects_m > FAIL_LIMIT);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    row_t     pin;
    reading_t want, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW_LEN) begin
          wlen_m   = cfg_data[WLEN_W-1:0];
          primed_m = 1'b0;
        end else begin
          step_m = cfg_data;
        end
        config_writes++;
      end
      if (sample_valid && !sample_stall) begin
        want = filter_sample(sample);
        if (pinned_readings.size() != 0) begin
          pin = pinned_readings.pop_front();
          if (pin.pinned) want = pin.reading;
        end
        pending_readings.push_back(want);
        samples_taken++;
      end
      if (result_valid && !result_stall) begin
        got = {filtered, rejected, sensor_fail};
        if (got.rejected) rejections_seen++;
        if (got.sensor_fail) alarms_seen++;
        if (pending_readings.size() == 0) begin
          failures++;
          if (failures <= PRINT_CAP)
            $display("%0t: result with none expected: filtered %0d rejected %0b sensor_fail %0b",
                     $time, got.filtered, got.rejected, got.sensor_fail);
        end else begin
          want = pending_readings.pop_front();
          results_checked++;
          if (got !== want) begin
            failures++;
            if (failures <= PRINT_CAP)
              $display("%0t: expected filtered %0d rejected %0b sensor_fail %0b, got %0d %0b %0b",
                       $time, want.filtered, want.rejected, want.sensor_fail,
                       got.filtered, got.rejected, got.sensor_fail);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("glitch_rejecting_moving_average regression: fail");
      $finish;
    end
  end

  // Result side: short random stalls, and one long hold-off so that the block backs up.
  initial begin : receiver
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // All driving tasks are entered and left at a falling edge.
  task automatic offer(input logic [SAMPLE_W-1:0] value);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int row, sent, phase, phase_items, k, j, burst, level, span;
    logic [CFG_DATA_W-1:0] step_pick, len_pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].kind == ROW_CONFIG) begin
        settle();
        write_reg(PLAN[row].index, PLAN[row].value);
      end else begin
        pinned_readings.push_back(PLAN[row]);
        offer(PLAN[row].value);
      end
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       step_pick = '0;
        1:       step_pick = '1;
        2:       step_pick = CFG_DATA_W'($urandom_range(1, 20));
        default: step_pick = CFG_DATA_W'($urandom_range(30, 3000));
      endcase
      // Raw window lengths include zero, values past the maximum and junk in the upper bits.
      case ($urandom_range(0, 9))
        0:       len_pick = 16'd0;
        1:       len_pick = 16'd1;
        2:       len_pick = CFG_DATA_W'(WIN_MAX);
        3:       len_pick = CFG_DATA_W'($urandom_range(WIN_MAX + 1, 63));
        4:       len_pick = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
        default: len_pick = CFG_DATA_W'($urandom_range(2, 8));
      endcase
      write_reg(REG_MAX_STEP, step_pick);
      write_reg(REG_WINDOW_LEN, len_pick);
      if (phase == 2) hold_request = 1'b1;

      level       = $urandom_range(1, 16'hFFFF);
      span        = int'(step_pick);
      phase_items = $urandom_range(20, 80);
      for (k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
        quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
        case ($urandom_range(0, 99)) inside
          [0:2]: begin
            // A run of hard glitches, long enough to take the rejection count past the alarm limit.
            burst = $urandom_range(12, 16);
            for (j = 0; j < burst; j++) offer((j % 2) ? 16'd0 : 16'hFFFF);
            sent += burst;
          end
          [3:8]: begin
            case ($urandom_range(0, 2))
              0:       offer(16'd0);
              1:       offer(16'hFFFF);
              default: offer(SAMPLE_W'($urandom_range(0, 16'hFFFF)));
            endcase
            sent++;
          end
          default: begin
            level += int'($urandom_range(0, span)) - span / 2;
            if (level < 1) level = 1;
            if (level > 16'hFFFF) level = 16'hFFFF;
            offer(level[SAMPLE_W-1:0]);
            sent++;
          end
        endcase
      end
      phase++;
    end

    settle();
    repeat (40) @(posedge clk);
    $display("Ran %0d samples over %0d phases with %0d register writes; %0d results checked.",
             samples_taken, phase, config_writes, results_checked);
    $display("Saw %0d rejected samples and %0d results with the sensor alarm raised.",
             rejections_seen, alarms_seen);
    if (failures == 0)
      $display("glitch_rejecting_moving_average regression: pass");
    else
      $display("glitch_rejecting_moving_average regression: fail");
    $finish;
  end

endmodule
